[hdl/fudv_pkg.sv]
// Shared types, constants and decode functions for the form URL decoder core.
// Used by form_url_decode_validate_core; has no dependencies of its own.
`timescale 1ns / 1ps

package fudv_pkg;

    localparam int BYTE_W      = 8;
    localparam int LINE_W      = 7;
    localparam int OUT_CNT_W   = 13;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LO_A    = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LO_F    = 8'h66;
    localparam logic [BYTE_W-1:0] CH_UP_A    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_F    = 8'h46;
    localparam logic [BYTE_W-1:0] PRINT_LO   = 8'd32;
    localparam logic [BYTE_W-1:0] PRINT_HI   = 8'd126;
    localparam logic [LINE_W-1:0] LINE_SAT   = 7'd127;
    localparam logic [LINE_W-1:0] MAX_LINE_RESET = 7'd80;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_PCT  = 2'd1,
        ESC_HEX1 = 2'd2
    } t_esc_phase;

    typedef struct packed {
        logic [LINE_W-1:0] line_len;
        logic              ok;
        logic              stopped;
    } t_chk;

    typedef struct packed {
        logic [BYTE_W-1:0]    data;
        logic                 last;
        logic                 text_ok;
        logic [OUT_CNT_W-1:0] count;
    } t_item;

    function automatic logic is_hex(input logic [BYTE_W-1:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LO_A && c <= CH_LO_F) ||
               (c >= CH_UP_A && c <= CH_UP_F);
    endfunction

    function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        v = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = c - CH_ZERO;
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            v = c - CH_LO_A + 8'd10;
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            v = c - CH_UP_A + 8'd10;
        end
        return v[3:0];
    endfunction

    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [BYTE_W-1:0] parse_pair(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        logic [BYTE_W-1:0] hb;
        hb = {4'd0, hex_val(b)};
        r  = 8'd0;
        if (is_hex(a)) begin
            r = is_hex(b) ? {hex_val(a), hex_val(b)} : {4'd0, hex_val(a)};
        end else if (is_blank(a) || a == CH_PLUS) begin
            r = is_hex(b) ? hb : 8'd0;
        end else if (a == CH_MINUS) begin
            r = is_hex(b) ? 8'd0 - hb : 8'd0;
        end
        return r;
    endfunction

    // Advances the printable and line-length check by one decoded byte.
    function automatic t_chk chk_update(input t_chk s, input logic [BYTE_W-1:0] d,
                                        input logic [LINE_W-1:0] max_len);
        t_chk r;
        r = s;
        if (!s.stopped && s.ok) begin
            if (d == 8'd0) begin
                r.stopped = 1'b1;
            end else if (d == CH_NEWLINE) begin
                r.line_len = '0;
            end else if (d < PRINT_LO || d > PRINT_HI) begin
                r.ok = 1'b0;
            end else begin
                if (s.line_len < LINE_SAT) begin
                    r.line_len = s.line_len + 7'd1;
                end
                if (r.line_len > max_len) begin
                    r.ok = 1'b0;
                end
            end
        end
        return r;
    endfunction

endpackage

[hdl/form_url_decode_validate_core.sv]
// Form URL decoder with printable-text and line-length checking.
// Results are registered in a four-entry result queue that drives the outputs.
// Throughput: one request per cycle while o_stall is low; a request that yields two
// results occupies the output for both of them in turn.
// Reset (synchronous, active low) clears the stream state and the queue and
// sets the line limit to 80. Depends on fudv_pkg.
`timescale 1ns / 1ps

module form_url_decode_validate_core #(
    parameter int MAX_TEXT_LEN = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [fudv_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                          i_in_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [fudv_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_out_last,
    output logic                          o_text_valid,
    output logic [fudv_pkg::OUT_CNT_W-1:0] o_decoded_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fudv_pkg::LINE_W-1:0]   i_cfg_data
);
    import fudv_pkg::*;

    localparam int CW = $clog2(MAX_TEXT_LEN + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TEXT_LEN);

    logic [LINE_W-1:0]  r_max_len;
    t_esc_phase         r_esc, n_esc;
    logic [BYTE_W-1:0]  r_held, n_held;
    t_chk               r_chk, n_chk;
    logic [CW-1:0]      r_bc, n_bc;

    t_item              r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_q_cnt;

    logic               accept;
    logic               pop;
    logic [1:0]         push;
    logic [BYTE_W-1:0]  plain;
    logic [BYTE_W-1:0]  d0, d1;
    logic               last0;
    t_chk               chk0, chk1, chk_cur;
    logic [CW-1:0]      cnt0, cnt1;
    t_item              res0, res1;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_q_cnt > Q_CNT_W'(Q_DEPTH - 2));
    assign accept      = i_valid && !o_stall;
    assign o_valid     = (r_q_cnt != '0);
    assign pop         = o_valid && !i_stall;

    assign o_out_byte      = r_q[r_rd_ptr].data;
    assign o_out_last      = r_q[r_rd_ptr].last;
    assign o_text_valid    = r_q[r_rd_ptr].text_ok;
    assign o_decoded_count = r_q[r_rd_ptr].count;

    assign plain = (i_in_byte == CH_PLUS) ? CH_SPACE : i_in_byte;

    always_comb begin
        n_esc = r_esc;
        if (accept) begin
            case (r_esc)
                ESC_PCT: begin
                    n_esc = i_in_last ? ESC_IDLE : ESC_HEX1;
                end
                ESC_HEX1: begin
                    n_esc = ESC_IDLE;
                end
                default: begin
                    n_esc = (i_in_byte == CH_PERCENT && !i_in_last) ? ESC_PCT : ESC_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        push   = 2'd0;
        d0     = plain;
        d1     = plain;
        last0  = i_in_last;
        n_held = r_held;
        case (r_esc)
            ESC_PCT: begin
                if (i_in_last) begin
                    push  = 2'd2;
                    d0    = CH_PERCENT;
                    last0 = 1'b0;
                end else begin
                    n_held = i_in_byte;
                end
            end
            ESC_HEX1: begin
                push   = 2'd1;
                d0     = parse_pair(r_held, i_in_byte);
                n_held = '0;
            end
            default: begin
                if (i_in_byte == CH_PERCENT) begin
                    if (i_in_last) begin
                        push = 2'd1;
                        d0   = CH_PERCENT;
                    end
                end else begin
                    push = 2'd1;
                end
            end
        endcase

        chk0 = chk_update(r_chk, d0, r_max_len);
        chk1 = chk_update(chk0, d1, r_max_len);
        cnt0 = (r_bc < CNT_MAX) ? r_bc + 1'b1 : r_bc;
        cnt1 = (cnt0 < CNT_MAX) ? cnt0 + 1'b1 : cnt0;

        res0.data    = d0;
        res0.last    = last0;
        res0.text_ok = chk0.ok;
        res0.count   = OUT_CNT_W'(cnt0);
        res1.data    = d1;
        res1.last    = 1'b1;
        res1.text_ok = chk1.ok;
        res1.count   = OUT_CNT_W'(cnt1);

        chk_cur = r_chk;
        n_bc    = r_bc;
        if (push == 2'd1) begin
            chk_cur = chk0;
            n_bc    = cnt0;
        end else if (push == 2'd2) begin
            chk_cur = chk1;
            n_bc    = cnt1;
        end
        n_chk = chk_cur;

        if (i_in_last) begin
            n_held         = '0;
            n_chk.line_len = '0;
            n_chk.ok       = 1'b1;
            n_chk.stopped  = 1'b0;
            n_bc           = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len    <= MAX_LINE_RESET;
            r_esc        <= ESC_IDLE;
            r_held       <= '0;
            r_chk.line_len <= '0;
            r_chk.ok     <= 1'b1;
            r_chk.stopped <= 1'b0;
            r_bc         <= '0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_q_cnt      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_len <= i_cfg_data;
            end
            if (accept) begin
                r_esc    <= n_esc;
                r_held   <= n_held;
                r_chk    <= n_chk;
                r_bc     <= n_bc;
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(push);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_q_cnt <= r_q_cnt + Q_CNT_W'(accept ? push : 2'd0) - Q_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && push != 2'd0) begin
            r_q[r_wr_ptr] <= res0;
        end
        if (accept && push == 2'd2) begin
            r_q[r_wr_ptr + 1'b1] <= res1;
        end
    end

endmodule

[test/fudv_decode_checker.sv]
// Watches the request, result and line-limit channels of the form URL decoder core,
// predicts the decoded bytes and verdicts, and counts mismatches. Depends on fudv_pkg.
`timescale 1ns / 1ps

module fudv_decode_checker #(
    parameter int MAX_TEXT_LEN = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    input  logic                             i_req_stall,
    input  logic [fudv_pkg::BYTE_W-1:0]      i_in_byte,
    input  logic                             i_in_last,
    input  logic                             i_rsp_valid,
    input  logic                             i_rsp_stall,
    input  logic [fudv_pkg::BYTE_W-1:0]      i_out_byte,
    input  logic                             i_out_last,
    input  logic                             i_text_valid,
    input  logic [fudv_pkg::OUT_CNT_W-1:0]   i_decoded_count,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [fudv_pkg::LINE_W-1:0]      i_cfg_data,
    output int                               o_errors,
    output int                               o_pending
);
    import fudv_pkg::*;

    t_item             decoded_q[$];
    logic [LINE_W-1:0] line_limit;
    t_esc_phase        esc;
    logic [BYTE_W-1:0] held;
    logic [LINE_W-1:0] line_len;
    logic              text_ok;
    logic              frozen;
    int                count;
    int                errors = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic int digit_of(input logic [BYTE_W-1:0] c);
        if (c >= "0" && c <= "9") begin
            return int'(c) - int'("0");
        end
        if (c >= "a" && c <= "f") begin
            return int'(c) - int'("a") + 10;
        end
        if (c >= "A" && c <= "F") begin
            return int'(c) - int'("A") + 10;
        end
        return -1;
    endfunction

    function automatic logic [BYTE_W-1:0] escape_value(input logic [BYTE_W-1:0] a,
                                                       input logic [BYTE_W-1:0] b);
        int da;
        int db;
        da = digit_of(a);
        db = digit_of(b);
        if (da >= 0) begin
            return (db >= 0) ? 8'(da * 16 + db) : 8'(da);
        end
        if (a == CH_SPACE || (a >= CH_TAB && a <= CH_CR) || a == CH_PLUS) begin
            return (db >= 0) ? 8'(db) : 8'd0;
        end
        if (a == CH_MINUS) begin
            return (db >= 0) ? 8'(-db) : 8'd0;
        end
        return 8'd0;
    endfunction

    task automatic restart_text();
        esc      = ESC_IDLE;
        held     = '0;
        line_len = '0;
        text_ok  = 1'b1;
        frozen   = 1'b0;
        count    = 0;
    endtask

    task automatic push_decoded(input logic [BYTE_W-1:0] d, input logic l);
        t_item e;
        if (!frozen && text_ok) begin
            if (d == 8'd0) begin
                frozen = 1'b1;
            end else if (d == CH_NEWLINE) begin
                line_len = '0;
            end else if (d < PRINT_LO || d > PRINT_HI) begin
                text_ok = 1'b0;
            end else begin
                if (line_len != LINE_SAT) begin
                    line_len = line_len + 7'd1;
                end
                if (line_len > line_limit) begin
                    text_ok = 1'b0;
                end
            end
        end
        if (count < MAX_TEXT_LEN) begin
            count++;
        end
        e.data    = d;
        e.last    = l;
        e.text_ok = text_ok;
        e.count   = count[OUT_CNT_W-1:0];
        decoded_q.push_back(e);
    endtask

    task automatic decode_request(input logic [BYTE_W-1:0] b, input logic l);
        case (esc)
            ESC_PCT: begin
                if (l) begin
                    push_decoded(CH_PERCENT, 1'b0);
                    push_decoded((b == CH_PLUS) ? CH_SPACE : b, 1'b1);
                end else begin
                    held = b;
                    esc  = ESC_HEX1;
                end
            end
            ESC_HEX1: begin
                push_decoded(escape_value(held, b), l);
                esc  = ESC_IDLE;
                held = '0;
            end
            default: begin
                if (b == CH_PERCENT) begin
                    if (l) begin
                        push_decoded(CH_PERCENT, 1'b1);
                    end else begin
                        esc = ESC_PCT;
                    end
                end else begin
                    push_decoded((b == CH_PLUS) ? CH_SPACE : b, l);
                end
            end
        endcase
        if (l) begin
            restart_text();
        end
    endtask

    task automatic check_field(input string name, input logic [OUT_CNT_W-1:0] want,
                               input logic [OUT_CNT_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Signals are sampled at the falling edge, where they hold the values that the
    // next rising edge will take.
    always @(negedge i_clk) begin
        t_item want;
        if (!i_rst_n) begin
            line_limit = MAX_LINE_RESET;
            restart_text();
            decoded_q.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (decoded_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, actual byte %0h last %0b",
                             $time, i_out_byte, i_out_last);
                end else begin
                    want = decoded_q.pop_front();
                    check_field("out_byte", 13'(want.data), 13'(i_out_byte));
                    check_field("out_last", 13'(want.last), 13'(i_out_last));
                    check_field("text_valid", 13'(want.text_ok), 13'(i_text_valid));
                    check_field("decoded_count", want.count, i_decoded_count);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                line_limit = i_cfg_data;
            end
            if (i_req_valid && !i_req_stall) begin
                decode_request(i_in_byte, i_in_last);
            end
        end
        o_pending <= decoded_q.size();
        o_errors  <= errors;
    end

endmodule

[test/tb_form_url_decode_validate_core.sv]
// Testbench top for form_url_decode_validate_core: drives directed and random encoded
// strings and line-limit writes, and gives the verdict.
// Depends on fudv_pkg and fudv_decode_checker.
`timescale 1ns / 1ps

module tb_form_url_decode_validate_core;
    import fudv_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int PHASE_BYTES  = 200;
    localparam int PHASES       = 8;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic [BYTE_W-1:0]    i_in_byte   = '0;
    logic                 i_in_last   = 1'b0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic [BYTE_W-1:0]    o_out_byte;
    logic                 o_out_last;
    logic                 o_text_valid;
    logic [OUT_CNT_W-1:0] o_decoded_count;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [LINE_W-1:0]    i_cfg_data  = '0;

    int fails;
    int pending;
    int quiet_cycles = 0;
    int sent_bytes   = 0;
    bit calm         = 1'b0;

    form_url_decode_validate_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_in_byte       (i_in_byte),
        .i_in_last       (i_in_last),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_out_last      (o_out_last),
        .o_text_valid    (o_text_valid),
        .o_decoded_count (o_decoded_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    fudv_decode_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_stall     (o_stall),
        .i_in_byte       (i_in_byte),
        .i_in_last       (i_in_last),
        .i_rsp_valid     (o_valid),
        .i_rsp_stall     (i_stall),
        .i_out_byte      (o_out_byte),
        .i_out_last      (o_out_last),
        .i_text_valid    (o_text_valid),
        .i_decoded_count (o_decoded_count),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_errors        (fails),
        .o_pending       (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 7);
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    always @(posedge i_clk) begin
        i_stall <= take_break();
    end

    always @(negedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic put_byte(input logic [BYTE_W-1:0] b, input logic l);
        while (take_break()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_in_last <= l;
        @(negedge i_clk);
        while (o_stall) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        sent_bytes++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            put_byte(s[i], i == s.len() - 1);
        end
    endtask

    task automatic send_line(input int n);
        logic [BYTE_W-1:0] c;
        for (int i = 0; i < n; i++) begin
            c = 8'($urandom_range(32, 126));
            if (c == CH_PERCENT) begin
                c = "x";
            end
            put_byte(c, i == n - 1);
        end
    endtask

    task automatic send_random_text();
        logic [BYTE_W-1:0] text[$];
        logic [BYTE_W-1:0] lead;
        int                pick;
        repeat ($urandom_range(1, 30)) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                text.push_back(8'($urandom_range(32, 126)));
            end else if (pick < 58) begin
                text.push_back(CH_PLUS);
            end else if (pick < 63) begin
                text.push_back(CH_NEWLINE);
            end else if (pick < 80) begin
                text.push_back(CH_PERCENT);
                text.push_back(hex_char());
                text.push_back(hex_char());
            end else if (pick < 86) begin
                case ($urandom_range(0, 4))
                    0: lead = CH_SPACE;
                    1: lead = 8'($urandom_range(9, 13));
                    2: lead = CH_PLUS;
                    3: lead = CH_MINUS;
                    default: lead = 8'($urandom_range(0, 255));
                endcase
                text.push_back(CH_PERCENT);
                text.push_back(lead);
                text.push_back(pick[0] ? hex_char() : 8'($urandom_range(0, 255)));
            end else if (pick < 93) begin
                text.push_back(8'($urandom_range(0, 255)));
            end else begin
                text.push_back(8'($urandom_range(1, 31)));
            end
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            text.push_back(CH_PERCENT);
        end else if (pick < 16) begin
            text.push_back(CH_PERCENT);
            text.push_back(pick[0] ? CH_PLUS : 8'($urandom_range(0, 255)));
        end
        foreach (text[i]) begin
            put_byte(text[i], i == text.size() - 1);
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LINE_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(negedge i_clk);
        while (!o_cfg_ready) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int phase_end;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("%4a+");
        send_text("% 7");
        send_text("%-1");
        send_text("%+Z");
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b1);
        send_text("%g5");
        send_text("%");
        send_text("%A");
        send_text("%+");
        send_text("a\nb");

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                settle();
                case (p)
                    1: write_limit(7'd1);
                    2: write_limit(7'd126);
                    3: write_limit(7'd0);
                    4: write_limit(7'd127);
                    default: write_limit(7'($urandom_range(0, 127)));
                endcase
            end
            calm = (p == 5);
            if (p == 2) begin
                send_line(135);
            end
            phase_end = sent_bytes + PHASE_BYTES;
            while (sent_bytes < phase_end) begin
                send_random_text();
            end
        end

        calm = 1'b0;
        settle();
        if (fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
